@@ hdl/cpu_control_register_branch_unit_assert.svh @@
// Assertion macros for the control register and branch unit.
`ifndef CPU_CONTROL_REGISTER_BRANCH_UNIT_ASSERT_SVH
`define CPU_CONTROL_REGISTER_BRANCH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CBU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBU_ASSERT(label, prop, msg)
`define CBU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ hdl/cbu_pkg.sv @@
`default_nettype none

package cbu_pkg;

    localparam int EXC_LEVELS_DEFAULT = 4;

    localparam logic [7:0]  PSW_C          = 8'h80;
    localparam logic [15:0] SP_EVEN_MASK   = 16'hFFFE;
    localparam logic [15:0] EPSW_L0_VALUE  = 16'h00FF;

    typedef enum logic [4:0] {
        CMD_ADDSP    = 5'd0,
        CMD_WR_ECSR  = 5'd1,
        CMD_WR_ELR   = 5'd2,
        CMD_WR_EPSW  = 5'd3,
        CMD_RD_ELR   = 5'd4,
        CMD_RD_SP    = 5'd5,
        CMD_WR_PSW   = 5'd6,
        CMD_RD_ECSR  = 5'd7,
        CMD_RD_EPSW  = 5'd8,
        CMD_RD_PSW   = 5'd9,
        CMD_WR_SP    = 5'd10,
        CMD_PSW_OR   = 5'd11,
        CMD_PSW_AND  = 5'd12,
        CMD_CPLC     = 5'd13,
        CMD_BC       = 5'd14,
        CMD_B        = 5'd15,
        CMD_BL       = 5'd16,
        CMD_RT       = 5'd17,
        CMD_RTI      = 5'd18
    } cmd_t;

    typedef enum logic [3:0] {
        COND_NC     = 4'd0,
        COND_C      = 4'd1,
        COND_GT     = 4'd2,
        COND_LE     = 4'd3,
        COND_GES    = 4'd4,
        COND_LTS    = 4'd5,
        COND_GTS    = 4'd6,
        COND_LES    = 4'd7,
        COND_NE     = 4'd8,
        COND_EQ     = 4'd9,
        COND_NV     = 4'd10,
        COND_OV     = 4'd11,
        COND_PS     = 4'd12,
        COND_NS     = 4'd13,
        COND_ALWAYS = 4'd14,
        COND_NEVER  = 4'd15
    } cond_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] operand_value;
        logic [7:0]  segment;
        logic        far_form;
        cond_t       condition;
    } item_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  csr;
        logic [15:0] link_pc;
        logic [7:0]  link_segment;
        logic [15:0] sp;
        logic [7:0]  psw;
    } core_state_t;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  segment;
        logic [7:0]  psw;
    } bank_rd_t;

    typedef struct packed {
        logic        pc_we;
        logic        segment_we;
        logic        psw_we;
        logic [15:0] data;
    } bank_wr_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        read_valid;
        logic [15:0] program_counter;
        logic [7:0]  code_segment;
        logic [7:0]  status_word;
        logic [15:0] stack_pointer;
        logic        branch_taken;
        logic        mask_block;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/cpu_control_register_branch_unit.sv @@
// Control register and branch unit: one command per transaction.
// A command passes the input register and then the result register on its way to m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; the state update paces it.
// Reset (rst_n low, asynchronous): PC, CSR, LR, LCSR, SP, PSW, all exception banks
// and wide_model clear to zero; both stages empty.
`default_nettype none

`include "cpu_control_register_branch_unit_assert.svh"

module cpu_control_register_branch_unit #(
    parameter int EXC_LEVELS = cbu_pkg::EXC_LEVELS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: wide_model in bit 0
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // operand_value[15:0], segment[23:16], far_form[24], condition[28:25], zero[31:29]
    input  wire logic [31:0] s_tdata,
    // command[4:0]
    input  wire logic [4:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[15:0], program_counter[31:16], code_segment[39:32],
    // status_word[47:40], stack_pointer[63:48], branch_taken[64], mask_block[65], zero[71:66]
    output logic [71:0]      m_tdata,
    // read_valid[0]
    output logic             m_tuser
);

    logic                 wide_model_reg;
    cbu_pkg::item_t       item_reg;
    logic                 item_valid_reg;
    logic                 item_valid_next;
    cbu_pkg::core_state_t state_reg;
    cbu_pkg::core_state_t state_next;
    cbu_pkg::result_t     result_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    cbu_pkg::bank_rd_t    bank_rd;
    cbu_pkg::bank_wr_t    bank_wr;
    cbu_pkg::bank_wr_t    bank_wr_gated;
    cbu_pkg::result_t     result_next;
    logic                 in_take;
    logic                 advance;
    logic                 fire;
    logic                 pipe_full;
    logic                 is_branch_cmd;
    logic                 is_sp_cmd;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = item_valid_reg && advance;
    assign s_tready  = !item_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        bank_wr_gated            = bank_wr;
        bank_wr_gated.pc_we      = bank_wr.pc_we && fire;
        bank_wr_gated.segment_we = bank_wr.segment_we && fire;
        bank_wr_gated.psw_we     = bank_wr.psw_we && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_model_reg <= 1'b0;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wide_model_reg <= cfg_data;
            end
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.command       <= cbu_pkg::cmd_t'(s_tuser);
            item_reg.operand_value <= s_tdata[15:0];
            item_reg.segment       <= s_tdata[23:16];
            item_reg.far_form      <= s_tdata[24];
            item_reg.condition     <= cbu_pkg::cond_t'(s_tdata[28:25]);
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    cbu_bank #(
        .EXC_LEVELS (EXC_LEVELS)
    ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .level (state_reg.psw[1:0]),
        .wr    (bank_wr_gated),
        .rd    (bank_rd)
    );

    cbu_exec u_exec (
        .item       (item_reg),
        .st         (state_reg),
        .bank_rd    (bank_rd),
        .wide_model (wide_model_reg),
        .st_next    (state_next),
        .bank_wr    (bank_wr),
        .result     (result_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result_reg.read_valid;
    assign m_tdata  = {6'd0,
                       result_reg.mask_block,
                       result_reg.branch_taken,
                       result_reg.stack_pointer,
                       result_reg.status_word,
                       result_reg.code_segment,
                       result_reg.program_counter,
                       result_reg.read_value};

    assign pipe_full     = item_valid_reg && out_valid_reg && !m_tready;
    assign is_branch_cmd = (item_reg.command == cbu_pkg::CMD_BC) ||
                           (item_reg.command == cbu_pkg::CMD_B) ||
                           (item_reg.command == cbu_pkg::CMD_BL) ||
                           (item_reg.command == cbu_pkg::CMD_RT) ||
                           (item_reg.command == cbu_pkg::CMD_RTI);
    assign is_sp_cmd     = (item_reg.command == cbu_pkg::CMD_ADDSP) ||
                           (item_reg.command == cbu_pkg::CMD_WR_SP);

    `CBU_ASSERT(a_fire_gives_result, fire |=> m_tvalid, "processed command produced no result")
    `CBU_ASSERT(a_stall_only_when_full, !s_tready |-> pipe_full, "input stalled, pipeline not full")
    `CBU_ASSERT(a_pc_held_by_non_branch, (fire && !is_branch_cmd) |=> $stable(state_reg.pc), "PC moved")
    `CBU_ASSERT(a_sp_even_wide, (fire && wide_model_reg && is_sp_cmd) |=> !state_reg.sp[0], "odd SP")

endmodule

`default_nettype wire

@@ hdl/cbu_bank.sv @@
`default_nettype none

module cbu_bank #(
    parameter int EXC_LEVELS = cbu_pkg::EXC_LEVELS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [1:0]       level,
    input  wire cbu_pkg::bank_wr_t wr,
    output cbu_pkg::bank_rd_t     rd
);

    localparam int IDX_W = (EXC_LEVELS > 1) ? $clog2(EXC_LEVELS) : 1;

    logic [15:0] elr_reg  [EXC_LEVELS];
    logic [7:0]  ecsr_reg [EXC_LEVELS];
    logic [7:0]  epsw_reg [EXC_LEVELS];

    logic             in_bank;
    logic [IDX_W-1:0] idx;

    assign in_bank = ({1'b0, level} < 3'(EXC_LEVELS));
    assign idx     = level[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < EXC_LEVELS; i++)
            begin
                elr_reg[i]  <= '0;
                ecsr_reg[i] <= '0;
                epsw_reg[i] <= '0;
            end
        end
        else if (in_bank)
        begin
            if (wr.pc_we)
            begin
                elr_reg[idx] <= wr.data;
            end
            if (wr.segment_we)
            begin
                ecsr_reg[idx] <= wr.data[7:0];
            end
            if (wr.psw_we)
            begin
                epsw_reg[idx] <= wr.data[7:0];
            end
        end
    end

    always_comb
    begin
        if (in_bank)
        begin
            rd.pc      = elr_reg[idx];
            rd.segment = ecsr_reg[idx];
            rd.psw     = epsw_reg[idx];
        end
        else
        begin
            rd = '0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/cbu_exec.sv @@
`default_nettype none

module cbu_exec (
    input  wire cbu_pkg::item_t       item,
    input  wire cbu_pkg::core_state_t st,
    input  wire cbu_pkg::bank_rd_t    bank_rd,
    input  wire logic                 wide_model,
    output cbu_pkg::core_state_t      st_next,
    output cbu_pkg::bank_wr_t         bank_wr,
    output cbu_pkg::result_t          result
);

    function automatic logic cond_met(input cbu_pkg::cond_t code, input logic [7:0] psw);
        logic c;
        logic z;
        logic s;
        logic ov;
        logic lts;
        logic met;
        c   = psw[7];
        z   = psw[6];
        s   = psw[5];
        ov  = psw[4];
        lts = ov ^ s;
        case (code)
            cbu_pkg::COND_NC:     met = !c;
            cbu_pkg::COND_C:      met = c;
            cbu_pkg::COND_GT:     met = !(z || c);
            cbu_pkg::COND_LE:     met = z || c;
            cbu_pkg::COND_GES:    met = !lts;
            cbu_pkg::COND_LTS:    met = lts;
            cbu_pkg::COND_GTS:    met = !(lts || z);
            cbu_pkg::COND_LES:    met = lts || z;
            cbu_pkg::COND_NE:     met = !z;
            cbu_pkg::COND_EQ:     met = z;
            cbu_pkg::COND_NV:     met = !ov;
            cbu_pkg::COND_OV:     met = ov;
            cbu_pkg::COND_PS:     met = !s;
            cbu_pkg::COND_NS:     met = s;
            cbu_pkg::COND_ALWAYS: met = 1'b1;
            default:              met = 1'b0;
        endcase
        return met;
    endfunction

    logic [15:0] disp;
    logic [15:0] sp_sum;
    logic [15:0] sp_raw;
    logic [15:0] rv;
    logic        rvalid;
    logic        taken;
    logic        mblock;
    logic [1:0]  lvl;

    assign disp   = {{8{item.operand_value[7]}}, item.operand_value[7:0]};
    assign sp_sum = st.sp + disp;
    assign lvl    = st.psw[1:0];

    always_comb
    begin
        st_next      = st;
        bank_wr      = '0;
        bank_wr.data = item.operand_value;
        sp_raw       = st.sp;
        rv           = '0;
        rvalid       = 1'b0;
        taken        = 1'b0;
        mblock       = 1'b0;
        case (item.command)
            cbu_pkg::CMD_ADDSP:   sp_raw = sp_sum;
            cbu_pkg::CMD_WR_ECSR: bank_wr.segment_we = 1'b1;
            cbu_pkg::CMD_WR_ELR:  bank_wr.pc_we = 1'b1;
            cbu_pkg::CMD_WR_EPSW: bank_wr.psw_we = (lvl != 2'd0);
            cbu_pkg::CMD_RD_ELR:
            begin
                rv     = bank_rd.pc;
                rvalid = 1'b1;
            end
            cbu_pkg::CMD_RD_SP:
            begin
                rv     = st.sp;
                rvalid = 1'b1;
            end
            cbu_pkg::CMD_WR_PSW:  st_next.psw = item.operand_value[7:0];
            cbu_pkg::CMD_RD_ECSR:
            begin
                rv     = {8'h00, bank_rd.segment};
                rvalid = 1'b1;
            end
            cbu_pkg::CMD_RD_EPSW:
            begin
                if (lvl != 2'd0)
                begin
                    rv     = {8'h00, bank_rd.psw};
                    rvalid = 1'b1;
                end
                else if (wide_model)
                begin
                    rv     = cbu_pkg::EPSW_L0_VALUE;
                    rvalid = 1'b1;
                end
            end
            cbu_pkg::CMD_RD_PSW:
            begin
                rv     = {8'h00, st.psw};
                rvalid = 1'b1;
            end
            cbu_pkg::CMD_WR_SP:   sp_raw = item.operand_value;
            cbu_pkg::CMD_PSW_OR:
            begin
                st_next.psw = st.psw | item.operand_value[7:0];
                mblock      = item.operand_value[3];
            end
            cbu_pkg::CMD_PSW_AND: st_next.psw = st.psw & item.operand_value[7:0];
            cbu_pkg::CMD_CPLC:    st_next.psw = st.psw ^ cbu_pkg::PSW_C;
            cbu_pkg::CMD_BC:
            begin
                if (cond_met(item.condition, st.psw))
                begin
                    st_next.pc = st.pc + {disp[14:0], 1'b0};
                    taken      = 1'b1;
                end
            end
            cbu_pkg::CMD_B:
            begin
                if (item.far_form)
                begin
                    st_next.csr = item.segment;
                end
                st_next.pc = item.operand_value;
                taken      = 1'b1;
            end
            cbu_pkg::CMD_BL:
            begin
                st_next.link_pc      = st.pc;
                st_next.link_segment = st.csr;
                if (item.far_form)
                begin
                    st_next.csr = item.segment;
                end
                st_next.pc = item.operand_value;
                taken      = 1'b1;
            end
            cbu_pkg::CMD_RT:
            begin
                st_next.csr = st.link_segment;
                st_next.pc  = st.link_pc;
                taken       = 1'b1;
            end
            cbu_pkg::CMD_RTI:
            begin
                st_next.csr = bank_rd.segment;
                st_next.pc  = bank_rd.pc;
                st_next.psw = bank_rd.psw;
                mblock      = 1'b1;
                taken       = 1'b1;
            end
            default:
            begin
            end
        endcase
        st_next.sp = wide_model ? (sp_raw & cbu_pkg::SP_EVEN_MASK) : sp_raw;
        if (!((item.command == cbu_pkg::CMD_ADDSP) || (item.command == cbu_pkg::CMD_WR_SP)))
        begin
            st_next.sp = st.sp;
        end
    end

    always_comb
    begin
        result.read_value      = rv;
        result.read_valid      = rvalid;
        result.program_counter = st_next.pc;
        result.code_segment    = st_next.csr;
        result.status_word     = st_next.psw;
        result.stack_pointer   = st_next.sp;
        result.branch_taken    = taken;
        result.mask_block      = mblock;
    end

endmodule

`default_nettype wire
